>>> rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int RAW_W = 20;
  localparam int CAL_W = 48;
  localparam int TEMP_W = 27;
  localparam int PRESS_W = 32;
  localparam int DIV_STEPS = 64;

  localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
  localparam logic [20:0] P_BASE = 21'd1048576;
  localparam logic [11:0] DIV_SCALE = 12'd3125;
  localparam logic [63:0] P1_BIAS = 64'h0000_8000_0000_0000;
  localparam logic signed [27:0] TEMP_ROUND = 28'sd128;

  typedef enum logic [1:0] {
    CFG_TEMP_CAL,
    CFG_PRESS_A,
    CFG_PRESS_B,
    CFG_PRESS_C
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

endpackage

>>> rtl/core/bpc_sample_if.sv
interface bpc_sample_if;
  import bpc_pkg::*;

  logic valid;
  logic ready;
  logic [RAW_W-1:0] raw_temp;
  logic [RAW_W-1:0] raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

>>> rtl/core/bpc_result_if.sv
interface bpc_result_if;
  import bpc_pkg::*;

  logic valid;
  logic ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic [PRESS_W-1:0] press_q24_8;
  logic press_valid;

  modport source (output valid, output temp_centi, output press_q24_8, output press_valid,
                  input ready);
  modport sink (input valid, input temp_centi, input press_q24_8, input press_valid,
                output ready);
endinterface

>>> rtl/core/bpc_temp.sv
module bpc_temp (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  bpc_pkg::cal_t cal,
  input  logic in_valid,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_press,
  output logic out_valid,
  output logic signed [26:0] out_temp,
  output logic signed [25:0] out_pa,
  output logic [19:0] out_adc_p
);
  import bpc_pkg::*;

  logic [4:0] v;
  logic [19:0] adc_p [0:3];
  logic signed [18:0] x1;
  logic signed [16:0] d1;
  logic signed [34:0] m2;
  logic signed [33:0] dd2;
  logic signed [23:0] a3;
  logic signed [36:0] b3;
  logic signed [24:0] fine4;
  logic signed [27:0] tsum;

  assign tsum = (28'(fine4) <<< 2) + 28'(fine4) + TEMP_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= $signed({2'b0, raw_temp[19:3]}) - $signed({2'b0, cal.t1, 1'b0});
      d1 <= $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, cal.t1});
      adc_p[0] <= raw_press;
      m2 <= x1 * $signed(cal.t2);
      dd2 <= d1 * d1;
      adc_p[1] <= adc_p[0];
      a3 <= m2[34:11];
      b3 <= $signed({1'b0, dd2[31:12]}) * $signed(cal.t3);
      adc_p[2] <= adc_p[1];
      fine4 <= 25'(a3) + 25'($signed(b3[36:14]));
      adc_p[3] <= adc_p[2];
      out_temp <= 27'($signed(tsum[27:8]));
      out_pa <= 26'(fine4) - FINE_OFFSET;
      out_adc_p <= adc_p[3];
    end
  end

  assign out_valid = v[4];
endmodule

>>> rtl/core/bpc_coef.sv
module bpc_coef (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  bpc_pkg::cal_t cal,
  input  logic in_valid,
  input  logic signed [25:0] in_pa,
  input  logic signed [26:0] in_temp,
  input  logic [19:0] in_adc_p,
  output logic out_valid,
  output logic [63:0] out_num,
  output logic signed [30:0] out_den,
  output logic signed [26:0] out_temp
);
  import bpc_pkg::*;

  logic [5:0] v;
  logic signed [26:0] temp [0:4];
  logic [19:0] adc_p [0:2];
  logic signed [51:0] aa1;
  logic signed [41:0] ap5_1, ap2_1, ap5_2, ap2_2;
  logic signed [67:0] prod6, prod3;
  logic [63:0] b6_2, a3_2;
  logic [63:0] b3, x3, n4;
  logic [47:0] lo4;
  logic [31:0] hi4, nh5;
  logic [43:0] nl5;
  logic signed [30:0] den5;
  logic [63:0] prod5;
  logic [20:0] pp;

  assign prod6 = aa1 * $signed(cal.p6);
  assign prod3 = aa1 * $signed(cal.p3);
  assign pp = P_BASE - 21'(adc_p[2]);
  assign prod5 = {hi4, 32'b0} + 64'(lo4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa1 <= in_pa * in_pa;
      ap5_1 <= in_pa * $signed(cal.p5);
      ap2_1 <= in_pa * $signed(cal.p2);
      temp[0] <= in_temp;
      adc_p[0] <= in_adc_p;

      b6_2 <= prod6[63:0];
      a3_2 <= prod3[63:0];
      ap5_2 <= ap5_1;
      ap2_2 <= ap2_1;
      temp[1] <= temp[0];
      adc_p[1] <= adc_p[0];

      b3 <= b6_2 + (64'(ap5_2) << 17) + (64'($signed(cal.p4)) << 35);
      x3 <= P1_BIAS + {{8{a3_2[63]}}, a3_2[63:8]} + (64'(ap2_2) << 12);
      temp[2] <= temp[1];
      adc_p[2] <= adc_p[1];

      lo4 <= x3[31:0] * cal.p1;
      hi4 <= 32'(x3[63:32] * 32'(cal.p1));
      n4 <= 64'({pp, 31'b0}) - b3;
      temp[3] <= temp[2];

      den5 <= prod5[63:33];
      nl5 <= n4[31:0] * DIV_SCALE;
      nh5 <= 32'(n4[63:32] * 32'(DIV_SCALE));
      temp[4] <= temp[3];

      out_num <= {nh5, 32'b0} + 64'(nl5);
      out_den <= den5;
      out_temp <= temp[4];
    end
  end

  assign out_valid = v[5];
endmodule

>>> rtl/core/bpc_div.sv
module bpc_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [63:0] in_num,
  input  logic signed [30:0] in_den,
  input  logic signed [26:0] in_temp,
  output logic out_valid,
  output logic [63:0] out_quo,
  output logic out_neg,
  output logic out_ok,
  output logic signed [26:0] out_temp
);
  import bpc_pkg::*;

  logic v [0:DIV_STEPS];
  logic [63:0] q [0:DIV_STEPS];
  logic [30:0] r [0:DIV_STEPS];
  logic [30:0] b [0:DIV_STEPS];
  logic neg [0:DIV_STEPS];
  logic ok [0:DIV_STEPS];
  logic signed [26:0] temp [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q[0] <= in_num[63] ? 64'(-in_num) : in_num;
      b[0] <= in_den[30] ? 31'(-in_den) : in_den;
      r[0] <= '0;
      neg[0] <= in_num[63] ^ in_den[30];
      ok[0] <= in_den != '0;
      temp[0] <= in_temp;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] trial;
    logic [32:0] diff;
    logic ge;

    assign trial = {r[k], q[k][63]};
    assign diff = {1'b0, trial} - {2'b0, b[k]};
    assign ge = !diff[32];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1] <= ge ? diff[30:0] : trial[30:0];
        q[k+1] <= {q[k][62:0], ge};
        b[k+1] <= b[k];
        neg[k+1] <= neg[k];
        ok[k+1] <= ok[k];
        temp[k+1] <= temp[k];
      end
    end
  end

  assign out_valid = v[DIV_STEPS];
  assign out_quo = q[DIV_STEPS];
  assign out_neg = neg[DIV_STEPS];
  assign out_ok = ok[DIV_STEPS];
  assign out_temp = temp[DIV_STEPS];
endmodule

>>> rtl/core/bpc_post.sv
module bpc_post (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  bpc_pkg::cal_t cal,
  input  logic in_valid,
  input  logic [63:0] in_quo,
  input  logic in_neg,
  input  logic in_ok,
  input  logic signed [26:0] in_temp,
  output logic out_valid,
  output logic [31:0] out_press,
  output logic out_ok,
  output logic signed [26:0] out_temp
);
  import bpc_pkg::*;

  logic [6:0] v;
  logic ok [0:5];
  logic signed [26:0] temp [0:5];
  logic [63:0] p1, p2, p3, p4, p5;
  logic [63:0] s, ll2, sq3, b3, b4, b5, a5, t6, prod8, prod9, rsum;
  logic [31:0] lh2, p8h2, h94;
  logic signed [48:0] p8l2, l94;

  assign s = {{13{p1[63]}}, p1[63:13]};
  assign prod8 = 64'(p8l2) + {p8h2, 32'b0};
  assign prod9 = 64'(l94) + {h94, 32'b0};
  assign rsum = {{8{t6[63]}}, t6[63:8]} + (64'($signed(cal.p7)) << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= in_neg ? 64'(-in_quo) : in_quo;
      ok[0] <= in_ok;
      temp[0] <= in_temp;

      ll2 <= s[31:0] * s[31:0];
      lh2 <= 32'(s[31:0] * s[63:32]);
      p8l2 <= $signed({1'b0, p1[31:0]}) * $signed(cal.p8);
      p8h2 <= 32'(p1[63:32] * 32'($signed(cal.p8)));
      p2 <= p1;
      ok[1] <= ok[0];
      temp[1] <= temp[0];

      sq3 <= ll2 + {lh2[30:0], 1'b0, 32'b0};
      b3 <= {{19{prod8[63]}}, prod8[63:19]};
      p3 <= p2;
      ok[2] <= ok[1];
      temp[2] <= temp[1];

      l94 <= $signed({1'b0, sq3[31:0]}) * $signed(cal.p9);
      h94 <= 32'(sq3[63:32] * 32'($signed(cal.p9)));
      b4 <= b3;
      p4 <= p3;
      ok[3] <= ok[2];
      temp[3] <= temp[2];

      a5 <= {{25{prod9[63]}}, prod9[63:25]};
      b5 <= b4;
      p5 <= p4;
      ok[4] <= ok[3];
      temp[4] <= temp[3];

      t6 <= p5 + a5 + b5;
      ok[5] <= ok[4];
      temp[5] <= temp[4];

      if (!ok[5] || rsum[63]) begin
        out_press <= '0;
      end else if (|rsum[62:32]) begin
        out_press <= '1;
      end else begin
        out_press <= rsum[31:0];
      end
      out_ok <= ok[5];
      out_temp <= temp[5];
    end
  end

  assign out_valid = v[6];
endmodule

>>> rtl/core/barometric_pressure_compensation.sv
// Barometric temperature and pressure compensation.
// Items arrive on the samples channel (raw_temp, raw_press) and leave on the
// results channel (temp_centi, press_q24_8, press_valid), one result per item.
// The four calibration registers are loaded through cfg_we, cfg_index and
// cfg_data, and should only be written while no item is in flight.
// The datapath is a fixed pipeline of 83 register stages: five for the
// temperature terms, six for the pressure coefficients, sixty-five for the
// bit-per-stage signed divider and seven for the final pressure terms, the
// last of which is the output register. One item is accepted every cycle
// while the results channel is not stalled.
// The whole pipeline advances whenever the output register is empty or its
// item is being taken, so a stall on the results channel holds every stage
// and removes ready on the samples channel in the same cycle.
// Reset clears all valid bits and the calibration registers.
// When the pressure divisor is zero, press_valid is low and press_q24_8 is zero.
module barometric_pressure_compensation (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data,
  bpc_sample_if.sink samples,
  bpc_result_if.source results
);
  import bpc_pkg::*;

  logic [CAL_W-1:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;
  cal_t cal;
  logic en;

  logic t_valid;
  logic signed [26:0] t_temp;
  logic signed [25:0] t_pa;
  logic [19:0] t_adc_p;

  logic c_valid;
  logic [63:0] c_num;
  logic signed [30:0] c_den;
  logic signed [26:0] c_temp;

  logic d_valid;
  logic [63:0] d_quo;
  logic d_neg, d_ok;
  logic signed [26:0] d_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_CAL: temp_cal <= cfg_data;
        CFG_PRESS_A:  press_cal_a <= cfg_data;
        CFG_PRESS_B:  press_cal_b <= cfg_data;
        CFG_PRESS_C:  press_cal_c <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cal.t1 = temp_cal[15:0];
  assign cal.t2 = temp_cal[31:16];
  assign cal.t3 = temp_cal[47:32];
  assign cal.p1 = press_cal_a[15:0];
  assign cal.p2 = press_cal_a[31:16];
  assign cal.p3 = press_cal_a[47:32];
  assign cal.p4 = press_cal_b[15:0];
  assign cal.p5 = press_cal_b[31:16];
  assign cal.p6 = press_cal_b[47:32];
  assign cal.p7 = press_cal_c[15:0];
  assign cal.p8 = press_cal_c[31:16];
  assign cal.p9 = press_cal_c[47:32];

  assign en = !results.valid || results.ready;
  assign samples.ready = en && !rst;

  bpc_temp u_temp (
    .clk(clk), .rst(rst), .en(en), .cal(cal),
    .in_valid(samples.valid), .raw_temp(samples.raw_temp), .raw_press(samples.raw_press),
    .out_valid(t_valid), .out_temp(t_temp), .out_pa(t_pa), .out_adc_p(t_adc_p)
  );

  bpc_coef u_coef (
    .clk(clk), .rst(rst), .en(en), .cal(cal),
    .in_valid(t_valid), .in_pa(t_pa), .in_temp(t_temp), .in_adc_p(t_adc_p),
    .out_valid(c_valid), .out_num(c_num), .out_den(c_den), .out_temp(c_temp)
  );

  bpc_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .in_num(c_num), .in_den(c_den), .in_temp(c_temp),
    .out_valid(d_valid), .out_quo(d_quo), .out_neg(d_neg), .out_ok(d_ok),
    .out_temp(d_temp)
  );

  bpc_post u_post (
    .clk(clk), .rst(rst), .en(en), .cal(cal),
    .in_valid(d_valid), .in_quo(d_quo), .in_neg(d_neg), .in_ok(d_ok), .in_temp(d_temp),
    .out_valid(results.valid), .out_press(results.press_q24_8),
    .out_ok(results.press_valid), .out_temp(results.temp_centi)
  );
endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  typedef struct {
    logic [TEMP_W-1:0] temp_centi;
    logic [PRESS_W-1:0] press_q24_8;
    logic press_valid;
  } reading_t;

  class compensation_checker;
    logic [CAL_W-1:0] cal[4];
    reading_t pending_readings[$];
    int errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors = 0;
    endfunction

    function longint uword(int idx, int pos);
      return longint'({48'b0, cal[idx][pos +: 16]});
    endfunction

    function longint sword(int idx, int pos);
      logic signed [15:0] w;
      w = cal[idx][pos +: 16];
      return longint'(w);
    endfunction

    function longint divide_to_zero(longint num, longint den);
      logic [63:0] mn, md, q;
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = mn / md;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function reading_t compensate(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
      reading_t r;
      longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, b, d, fine, temp, p;
      adc_t = longint'({44'b0, raw_t});
      adc_p = longint'({44'b0, raw_p});
      t1 = uword(CFG_TEMP_CAL, 0);
      t2 = sword(CFG_TEMP_CAL, 16);
      t3 = sword(CFG_TEMP_CAL, 32);
      p1 = uword(CFG_PRESS_A, 0);
      p2 = sword(CFG_PRESS_A, 16);
      p3 = sword(CFG_PRESS_A, 32);
      p4 = sword(CFG_PRESS_B, 0);
      p5 = sword(CFG_PRESS_B, 16);
      p6 = sword(CFG_PRESS_B, 32);
      p7 = sword(CFG_PRESS_C, 0);
      p8 = sword(CFG_PRESS_C, 16);
      p9 = sword(CFG_PRESS_C, 32);
      a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      temp = (fine * 5 + 128) >>> 8;
      a = fine - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
      r.temp_centi = temp[TEMP_W-1:0];
      r.press_q24_8 = '0;
      r.press_valid = 1'b0;
      if (a != 0) begin
        r.press_valid = 1'b1;
        p = 1048576 - adc_p;
        p = divide_to_zero(((p <<< 31) - b) * 3125, a);
        d = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        b = (p8 * p) >>> 19;
        p = ((p + d + b) >>> 8) + (p7 <<< 4);
        if (p < 0) r.press_q24_8 = '0;
        else if (p > longint'(64'hFFFF_FFFF)) r.press_q24_8 = '1;
        else r.press_q24_8 = p[31:0];
      end
      return r;
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
      pending_readings.push_back(compensate(raw_t, raw_p));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [TEMP_W-1:0] t, logic [PRESS_W-1:0] p, logic v);
      reading_t e;
      if (pending_readings.size() == 0) begin
        report("unexpected item", {37'b0, t}, 64'b0);
        return;
      end
      e = pending_readings.pop_front();
      if (t !== e.temp_centi) report("temp_centi", {37'b0, t}, {37'b0, e.temp_centi});
      if (p !== e.press_q24_8) report("press_q24_8", {32'b0, p}, {32'b0, e.press_q24_8});
      if (v !== e.press_valid) report("press_valid", {63'b0, v}, {63'b0, e.press_valid});
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [47:0] cfg_data;

  bpc_sample_if samples_ch();
  bpc_result_if results_ch();

  barometric_pressure_compensation DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(samples_ch.sink),
    .results(results_ch.source)
  );

  compensation_checker checker_h = new();
  int samples_taken = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit steady_flow = 0;
  bit held_off = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    samples_ch.valid = 0;
    samples_ch.raw_temp = '0;
    samples_ch.raw_press = '0;
    results_ch.ready = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
  end

  function int pick_gap();
    if (steady_flow) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (results_ch.valid && results_ch.ready)
        checker_h.check_result(results_ch.temp_centi, results_ch.press_q24_8,
                               results_ch.press_valid);
      if (!held_off && samples_taken >= 250) begin
        held_off = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 0;
      end else if (results_ch.ready && pick_gap() > 0) begin
        stall_left = pick_gap();
        results_ch.ready <= 0;
      end else begin
        results_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cal(cfg_idx_t idx, logic [47:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    checker_h.cal[idx] = value;
  endtask

  task automatic load_cal(logic [47:0] t, logic [47:0] pa, logic [47:0] pb, logic [47:0] pc);
    write_cal(CFG_TEMP_CAL, t);
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_C, pc);
    cfg_we <= 0;
  endtask

  task automatic send_sample(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid <= 1;
    samples_ch.raw_temp <= raw_t;
    samples_ch.raw_press <= raw_p;
    do @(posedge clk); while (!samples_ch.ready);
    checker_h.note_sample(samples_ch.raw_temp, samples_ch.raw_press);
    samples_taken++;
  endtask

  task automatic drain();
    samples_ch.valid <= 0;
    while (checker_h.pending_readings.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] random_raw(bit typical_band);
    if (typical_band) return RAW_W'($urandom_range(300000, 700000));
    return RAW_W'($urandom);
  endfunction

  task automatic random_samples(int n);
    repeat (n) send_sample(random_raw($urandom_range(0, 1)), random_raw($urandom_range(0, 1)));
  endtask

  function automatic logic [47:0] pack3(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
    return {hi, mid, lo};
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] w);
    return w + 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  logic [47:0] typ_t, typ_a, typ_b, typ_c;

  initial begin
    typ_t = pack3(16'd27504, 16'd26435, -16'sd1000);
    typ_a = pack3(16'd36477, -16'sd10685, 16'd3024);
    typ_b = pack3(16'd2855, 16'd140, -16'sd7);
    typ_c = pack3(16'd15500, -16'sd14600, 16'd6000);
    @(negedge rst);
    @(posedge clk);

    // Registers still at reset: the divisor is zero for every item.
    send_sample('0, '0);
    send_sample('1, '1);
    random_samples(20);
    drain();

    load_cal(typ_t, typ_a, typ_b, typ_c);
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample('0, '1);
    send_sample('1, '0);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h80000, 20'h80000);
    send_sample(20'd519888, 20'd0);
    send_sample(20'd519888, 20'hFFFFF);
    random_samples(100);
    drain();

    // Zero P1 makes the divisor zero while temperature is still valid.
    load_cal(typ_t, pack3(16'd0, -16'sd10685, 16'd3024), typ_b, typ_c);
    send_sample(20'd519888, 20'd415148);
    random_samples(20);
    drain();

    load_cal('1, '1, '1, '1);
    send_sample('0, '0);
    send_sample('1, '1);
    random_samples(60);
    drain();

    load_cal(48'h8000_8000_8000, 48'h8000_8000_FFFF, 48'h7FFF_7FFF_7FFF,
             48'h7FFF_8000_7FFF);
    send_sample('0, '0);
    send_sample('1, '1);
    random_samples(60);
    drain();

    steady_flow = 1;
    load_cal(pack3(nudge(16'd27504), nudge(16'd26435), nudge(-16'sd1000)),
             pack3(nudge(16'd36477), nudge(-16'sd10685), nudge(16'd3024)),
             pack3(nudge(16'd2855), nudge(16'd140), nudge(-16'sd7)),
             pack3(nudge(16'd15500), nudge(-16'sd14600), nudge(16'd6000)));
    random_samples(120);
    drain();
    steady_flow = 0;

    repeat (4) begin
      load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      random_samples(40);
      drain();
    end

    if (checker_h.errors == 0 && checker_h.pending_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_sample_if.sv
rtl/core/bpc_result_if.sv
rtl/core/bpc_temp.sv
rtl/core/bpc_coef.sv
rtl/core/bpc_div.sv
rtl/core/bpc_post.sv
rtl/core/barometric_pressure_compensation.sv
tb/testbench.sv
